@@ design/moving_average_filter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the moving average filter
// Shared shorthand for the concurrent checks in the filter modules.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_TOP_MACROS_SVH
`define MOVING_AVERAGE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MAF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("moving average filter check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MAF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("moving average filter check failed");

`endif

@@ design/maf_pkg.sv @@
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared constants, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package maf_pkg;

	localparam int MAF_MAX_WINDOW  = 32;
	localparam int MAF_SAMPLE_BITS = 16;
	localparam int MAF_CFG_W       = 6;
	localparam logic [MAF_CFG_W-1:0] MAF_LEN_RESET = 6'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_UPD,
		S_DIV,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic update;
		logic div_step;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic result_due;
		logic out_busy;
	} status_t;

endpackage

@@ design/maf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module maf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/maf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Moving average filter controller
// Sequences sample capture, window update, serial divide and result load.
// ----------------------------------------------------------------------------
`include "moving_average_filter_top_macros.svh"

module maf_ctrl import maf_pkg::*; #(
	parameter int SUM_W = 21
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_axis_tvalid,
	output logic    s_axis_tready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int CNT_W = $clog2(SUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

	state_t            state_q, state_n;
	logic [CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == S_UPD) begin
				cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.capture = 1'b1;
					state_n     = S_READ;
				end
			end
			S_READ: begin
				state_n = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_n    = status.result_due ? S_DIV : S_IDLE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				// The finished quotient waits here until the output register frees up.
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	`MAF_ASSERT_NEXT(a_no_result_returns, (state_q == S_UPD) && !status.result_due, state_q == S_IDLE)
	`MAF_ASSERT_NEXT(a_div_ends, (state_q == S_DIV) && (cnt_q == CNT_LAST), state_q == S_DONE)
	`MAF_ASSERT_IMPL(a_load_when_free, cmd.load_out, !status.out_busy)

endmodule

@@ design/maf_datapath.sv @@
// ----------------------------------------------------------------------------
// Moving average filter datapath
// Window ring, running sum, restoring divider and output register.
// ----------------------------------------------------------------------------
`include "moving_average_filter_top_macros.svh"

module maf_datapath import maf_pkg::*; #(
	parameter int MAX_WINDOW  = MAF_MAX_WINDOW,
	parameter int SAMPLE_BITS = MAF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [MAF_CFG_W-1:0]   cfg_wdata,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   frame_end,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic                   m_axis_tready,
	output logic                   m_axis_tvalid,
	output logic [SAMPLE_BITS-1:0] average,
	output logic                   last_of_frame
);

	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
	localparam int CMP_W  = (LEN_W > MAF_CFG_W) ? LEN_W : MAF_CFG_W;

	logic [MAF_CFG_W-1:0]   cfg_q;
	logic [LEN_W-1:0]       len;
	logic [SUM_W-1:0]       sum_q, sum_n;
	logic [LEN_W-1:0]       fill_q, fill_n;
	logic [SLOT_W-1:0]      slot_q, slot_eff;
	logic [LEN_W-1:0]       slot_inc;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   end_q;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic                   window_full;
	logic [SUM_W-1:0]       dvd_q, dvd_n;
	logic [LEN_W-1:0]       rem_q, rem_n;
	logic                   neg_q;
	logic                   last_q;
	logic [LEN_W:0]         trial;
	logic                   ge;
	logic [SUM_W-1:0]       quot;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic                   last_out_q;

	// Effective length: zero means one, anything past the ring size saturates.
	always_comb begin
		if (cfg_q == '0) begin
			len = LEN_W'(1);
		end else if (CMP_W'(cfg_q) > CMP_W'(MAX_WINDOW)) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(cfg_q);
		end
	end

	assign slot_eff = (LEN_W'(slot_q) >= len) ? '0 : slot_q;
	assign slot_inc = LEN_W'(slot_eff) + 1'b1;

	maf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (slot_eff),
		.wdata (sample_q),
		.raddr (slot_eff),
		.rdata (old_sample)
	);

	always_comb begin
		window_full = (fill_q >= len);
		sum_n       = sum_q + {{(SUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
		fill_n      = fill_q;
		if (window_full) begin
			sum_n = sum_n - {{(SUM_W-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
		end else begin
			fill_n = fill_q + 1'b1;
		end
	end

	assign status.result_due = (fill_n >= len);
	assign status.out_busy   = out_valid_q && !m_axis_tready;

	// One restoring step: the divisor is the window length.
	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		ge    = (trial >= {1'b0, len});
		rem_n = ge ? LEN_W'(trial - {1'b0, len}) : LEN_W'(trial);
		dvd_n = {dvd_q[SUM_W-2:0], ge};
	end

	assign quot = neg_q ? (~dvd_q + 1'b1) : dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= MAF_LEN_RESET;
			sum_q  <= '0;
			fill_q <= '0;
			slot_q <= '0;
		end else if (cfg_we) begin
			cfg_q  <= cfg_wdata;
			sum_q  <= '0;
			fill_q <= '0;
			slot_q <= '0;
		end else if (cmd.update) begin
			if (end_q) begin
				sum_q  <= '0;
				fill_q <= '0;
				slot_q <= '0;
			end else begin
				sum_q  <= sum_n;
				fill_q <= fill_n;
				slot_q <= (slot_inc >= len) ? '0 : SLOT_W'(slot_inc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
			end_q    <= frame_end;
		end
		if (cmd.update) begin
			neg_q  <= sum_n[SUM_W-1];
			dvd_q  <= sum_n[SUM_W-1] ? (~sum_n + 1'b1) : sum_n;
			rem_q  <= '0;
			last_q <= end_q;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
		if (cmd.load_out) begin
			avg_q      <= quot[SAMPLE_BITS-1:0];
			last_out_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign average       = avg_q;
	assign last_of_frame = last_out_q;

	`MAF_ASSERT_IMPL(a_fill_bounded, 1'b1, fill_q <= len)
	`MAF_ASSERT_IMPL(a_slot_in_window, 1'b1, LEN_W'(slot_q) < len)
	`MAF_ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_valid_q)

endmodule

@@ design/moving_average_filter_top.sv @@
// ----------------------------------------------------------------------------
// Moving average filter top level
// Streaming boxcar smoother over a configurable window of signed samples.
// ----------------------------------------------------------------------------
// Each sample enters on the slave stream and joins a window of the last
// window_length samples of its frame. While the window is not yet full a
// sample passes the capture, read and update states and gives no result.
// Once it is full, every sample gives the window sum divided by the length,
// truncated toward zero, by the bit-serial restoring divider that forms
// one quotient bit per cycle. A result waits in the output register while
// the next sample is taken in. The sample marked by tlast ends the frame:
// its result, if any, carries tlast, and the window then empties.
// A write to the length register also empties the window. Length zero acts as
// one and lengths above MAX_WINDOW act as MAX_WINDOW.
// ----------------------------------------------------------------------------
module moving_average_filter_top import maf_pkg::*; #(
	parameter int MAX_WINDOW  = MAF_MAX_WINDOW,
	parameter int SAMPLE_BITS = MAF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [MAF_CFG_W-1:0]                cfg_wdata,   // window_length
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata, // sample, zero pad
	input  logic                                s_axis_tlast, // frame_end
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata, // average, zero pad
	output logic                                m_axis_tlast  // last_of_frame
);

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);

	cmd_t                   cmd;
	status_t                status;
	logic [SAMPLE_BITS-1:0] average;

	maf_ctrl #(
		.SUM_W (SUM_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	maf_datapath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.sample        (s_axis_tdata[SAMPLE_BITS-1:0]),
		.frame_end     (s_axis_tlast),
		.cmd           (cmd),
		.status        (status),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.average       (average),
		.last_of_frame (m_axis_tlast)
	);

	assign m_axis_tdata = DATA_W'(average);

endmodule

@@ tb/maf_average_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter checker
// Watches the length register and both streams, predicts every windowed
// average from the accepted samples and compares it with the output stream.
// ----------------------------------------------------------------------------
module maf_average_checker import maf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [MAF_CFG_W-1:0]       cfg_wdata,     // window_length
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [MAF_SAMPLE_BITS-1:0] s_axis_tdata,  // sample
	input  logic                       s_axis_tlast,  // frame_end
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [MAF_SAMPLE_BITS-1:0] m_axis_tdata,  // average
	input  logic                       m_axis_tlast,  // last_of_frame
	output int                         fail_count,
	output int                         pending
);

	typedef struct packed {
		logic signed [MAF_SAMPLE_BITS-1:0] average;
		logic                              last_of_frame;
	} average_t;

	average_t                          expected_averages[$];
	logic signed [MAF_SAMPLE_BITS-1:0] held_samples [MAF_MAX_WINDOW];
	logic signed [20:0]                window_sum;
	logic [5:0]                        fill_count;
	logic [4:0]                        write_slot;
	logic [MAF_CFG_W-1:0]              window_length;
	int                                errors;

	function automatic int effective_length(input logic [MAF_CFG_W-1:0] len);
		if (len == '0) return 1;
		if (len > MAF_MAX_WINDOW) return MAF_MAX_WINDOW;
		return int'(len);
	endfunction

	task automatic clear_window();
		window_sum = '0;
		fill_count = '0;
		write_slot = '0;
	endtask

	task automatic take_sample(input logic signed [MAF_SAMPLE_BITS-1:0] smp,
			input logic frame_end);
		int       len;
		int       slot;
		int       quotient;
		average_t res;
		len  = effective_length(window_length);
		slot = int'(write_slot);
		if (slot >= len) slot = 0;
		// A full window drops its oldest sample, which sits in the slot now reused.
		if (fill_count >= len)
			window_sum = window_sum - held_samples[slot];
		else
			fill_count = fill_count + 6'd1;
		held_samples[slot] = smp;
		window_sum = window_sum + smp;
		slot++;
		write_slot = (slot >= len) ? 5'd0 : 5'(slot);
		if (fill_count >= len) begin
			// SystemVerilog integer division truncates toward zero, as the block does.
			quotient = int'(window_sum) / len;
			res.average       = quotient[MAF_SAMPLE_BITS-1:0];
			res.last_of_frame = frame_end;
			expected_averages.push_back(res);
		end
		if (frame_end) clear_window();
	endtask

	always @(posedge clk or negedge arst_n) begin
		average_t got;
		average_t want;
		if (!arst_n) begin
			expected_averages.delete();
			window_length = MAF_LEN_RESET;
			clear_window();
			errors = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				window_length = cfg_wdata;
				clear_window();
			end
			if (s_axis_tvalid && s_axis_tready)
				take_sample(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.average       = m_axis_tdata;
				got.last_of_frame = m_axis_tlast;
				if (expected_averages.size() == 0) begin
					$display("%0t: unexpected transfer, average %0d last %0b", $time,
						got.average, got.last_of_frame);
					errors++;
				end else begin
					want = expected_averages.pop_front();
					if (got.average !== want.average) begin
						$display("%0t: average mismatch, expected %0d, actual %0d", $time,
							want.average, got.average);
						errors++;
					end
					if (got.last_of_frame !== want.last_of_frame) begin
						$display("%0t: tlast mismatch, expected %0b, actual %0b", $time,
							want.last_of_frame, got.last_of_frame);
						errors++;
					end
				end
			end
			fail_count <= errors;
			pending    <= expected_averages.size();
		end
	end

endmodule

@@ tb/tb_moving_average_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter testbench
// Drives directed and random framed samples under several window lengths,
// with bursty input and a stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_moving_average_filter_top;
	import maf_pkg::*;

	localparam int CYCLE_LIMIT  = 400_000;
	localparam int SETTLE_TICKS = 40;
	localparam int PHASE_ITEMS  = 150;

	logic                       clk;
	logic                       arst_n        = 1'b0;
	logic                       cfg_we        = 1'b0;
	logic [MAF_CFG_W-1:0]       cfg_wdata     = '0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [MAF_SAMPLE_BITS-1:0] s_axis_tdata  = '0;
	logic                       s_axis_tlast  = 1'b0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [MAF_SAMPLE_BITS-1:0] m_axis_tdata;
	logic                       m_axis_tlast;

	int                   fail_count;
	int                   pending;
	int                   cycle_count = 0;
	int                   burst_left  = 0;
	int                   stall_mode  = 0;
	int                   mode_left   = 0;
	logic [MAF_CFG_W-1:0] cur_length  = MAF_LEN_RESET;

	moving_average_filter_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	maf_average_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver switches between always ready, coin-flip ready and mostly stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(10, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	function automatic logic [MAF_SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2, 3: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	// Called right after a rising edge; returns after the transfer and any idle gap.
	task automatic push_sample(input logic [MAF_SAMPLE_BITS-1:0] smp, input logic lst);
		int gap;
		s_axis_tdata  <= smp;
		s_axis_tlast  <= lst;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 10);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Waits until every expected average has arrived and the block has gone quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_length(input logic [MAF_CFG_W-1:0] len);
		settle();
		cfg_we     <= 1'b1;
		cfg_wdata  <= len;
		cur_length = len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly frames that fill the window, a few short ones that may end before it is full.
	// The phase may stop mid-frame, so the next length write empties a partial window.
	task automatic random_phase(input int n_items);
		int sent;
		int frame_len;
		int eff;
		int pos;
		eff  = (cur_length == '0) ? 1 : (cur_length > MAF_MAX_WINDOW) ? MAF_MAX_WINDOW
			: int'(cur_length);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 7) == 0)
				frame_len = $urandom_range(1, eff);
			else
				frame_len = eff + $urandom_range(0, 2 * eff + 4);
			for (pos = 1; pos <= frame_len && sent < n_items; pos++) begin
				push_sample(random_sample(), pos == frame_len);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default length of four: full-scale windows, sums that truncate toward zero.
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h8000, 1'b1);
		// A frame shorter than the window gives nothing.
		push_sample(16'h0005, 1'b0);
		push_sample(16'hFFF9, 1'b1);
		// The window fills exactly on the frame end.
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'hFFFE, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'h0000, 1'b1);
		// Length zero acts as one.
		write_length(6'd0);
		push_sample(16'hFFFD, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b1);

		write_length(6'd1);
		random_phase(PHASE_ITEMS);
		write_length(6'd32);
		random_phase(PHASE_ITEMS);
		write_length(6'd63);
		random_phase(PHASE_ITEMS);
		write_length(6'd0);
		random_phase(PHASE_ITEMS);
		write_length(6'd33);
		random_phase(PHASE_ITEMS);
		write_length(6'd2);
		random_phase(PHASE_ITEMS);
		write_length(6'd7);
		random_phase(PHASE_ITEMS);
		write_length(6'($urandom_range(1, 32)));
		random_phase(PHASE_ITEMS);

		settle();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
